[hw/rtl/bilinear_grid_interpolator_defines.svh]
// Assertion macros shared by the bilinear grid interpolator RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef BILINEAR_GRID_INTERPOLATOR_DEFINES_SVH
`define BILINEAR_GRID_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define BGI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BGI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/bgi_pkg.sv]
// Package for the bilinear grid interpolator: item kinds, register codes,
// shared types and divider constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bgi_pkg;

   // item kinds carried in req_tuser
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ROW_BP = 2'd0;
   localparam kind_type KIND_COL_BP = 2'd1;
   localparam kind_type KIND_GRID   = 2'd2;
   localparam kind_type KIND_QUERY  = 2'd3;

   // configuration register indexes
   typedef logic csr_idx_type;
   localparam csr_idx_type CSR_ROW_COUNT = 1'b0;
   localparam csr_idx_type CSR_COL_COUNT = 1'b1;

   typedef logic signed [31:0] q16_type;

   // numerators of the three divisions
   localparam int NUM_W = 100;
   typedef logic signed [NUM_W-1:0] num_type;

   // divider: quotient bits, bits per stage, stage count, latency
   localparam int QBITS   = 32;
   localparam int DIV_SPS = 2;
   localparam int DIV_NS  = QBITS / DIV_SPS;
   localparam int DIV_LAT = DIV_NS + 2;

   // breakpoint write beat
   typedef struct packed {
      logic          en;
      logic [7:0]    idx;
      logic [31:0]   data;
   } bp_wr_type;

endpackage

`default_nettype wire

[hw/rtl/bilinear_grid_interpolator.sv]
// Bilinear grid interpolator: 2-D lookup table in signed Q16.16.
// Depends on bgi_pkg, bgi_axis, bgi_div and the defines header.
//
// Use: req beats carry a kind in req_tuser. Kinds row breakpoint, column
// breakpoint and grid value store entry_value at entry_index and give no
// result. A query beat clamps (query_x, query_y) to the table, finds the
// cell, and one rsp beat returns value, slope_x, slope_y (saturated) and
// the degenerate-cell flag in rsp_tuser. Grid index is row + row_count*col.
// csr_wr_en/csr_index/csr_wdata write row_count and col_count, idle only.
// Pipeline: 28 register stages (nine front stages, the 18-stage divider
// with two quotient bits per stage, the output register), the first
// loaded at acceptance. Throughput: one query per cycle while no stall
// holds the pipeline. A load beat waits while a query sits in the first
// three stages, which read the breakpoints and the grid.
// Stall: when rsp_tvalid is high and rsp_tready low the whole pipeline
// holds, req_tready drops, nothing is lost or repeated.
// Reset: clears valid bits and sets both counts to 2. Table stores are
// not cleared and read undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_grid_interpolator_defines.svh"

module bilinear_grid_interpolator #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // entry_index[7:0], entry_value[39:8], query_x[71:40], query_y[103:72]
   input  logic [103:0]        req_tdata,
   // kind[1:0]
   input  bgi_pkg::kind_type   req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // interp_value[31:0], slope_x[63:32], slope_y[95:64]
   output logic [95:0]         rsp_tdata,
   // degenerate_cell[0]
   output logic [0:0]          rsp_tuser,
   input  logic                csr_wr_en,
   input  bgi_pkg::csr_idx_type csr_index,
   input  logic [4:0]          csr_wdata
);
   import bgi_pkg::*;

   localparam int RW       = $clog2(MAX_ROWS);
   localparam int CW       = $clog2(MAX_COLS);
   localparam int GD       = (MAX_ROWS * MAX_COLS > 256) ? 256 : MAX_ROWS * MAX_COLS;
   localparam int GAW      = $clog2(GD);
   localparam int AW       = (CW + 6 > GAW) ? CW + 6 : GAW + 1;
   localparam int PIPE_LEN = 10 + DIV_LAT;
   localparam logic [4:0] ROW_CAP = (MAX_ROWS > 31) ? 5'd31 : 5'(MAX_ROWS);
   localparam logic [4:0] COL_CAP = (MAX_COLS > 31) ? 5'd31 : 5'(MAX_COLS);

   // payload fields
   logic [7:0]   entry_index;
   q16_type      entry_value, query_x, query_y;

   // control
   logic [4:0]   row_count_ff, col_count_ff;
   logic [4:0]   row_eff, col_eff;
   logic [PIPE_LEN-1:0] vld_ff;
   logic         adv, accept, is_query, front_busy, grid_we;
   bp_wr_type    row_wr, col_wr;

   // axis outputs
   logic [RW-1:0] row_cell;
   logic [CW-1:0] col_cell;
   q16_type       row_lo, row_hi, row_pos, col_lo, col_hi, col_pos;

   // grid copies, one per corner
   q16_type       grid0_mem [GD];
   q16_type       grid1_mem [GD];
   q16_type       grid2_mem [GD];
   q16_type       grid3_mem [GD];
   logic [AW-1:0] base_w, base_up_w, base_rt_w, base_dg_w;
   q16_type       a_ff [4];

   // stage 5
   logic signed [32:0] dx_ff, dy_ff, ux1_ff, ux0_ff, vy1_ff, vy0_ff;
   logic signed [32:0] da_ff, db_ff, dc_ff, dd_ff;
   q16_type            a5_ff [4];
   // stage 6
   logic signed [64:0] p_ff [4];
   logic signed [65:0] qa_ff, qb_ff, qc_ff, qd_ff;
   logic signed [32:0] vy1_s6_ff, vy0_s6_ff;
   logic [63:0]        dmag6_ff;
   logic               degen6_ff, dneg6_ff;
   logic [31:0]        dxm, dym;
   // stage 7
   logic signed [65:0] pph_ff [4];
   logic signed [65:0] ppl_ff [4];
   logic signed [65:0] pph_in [4];
   logic signed [65:0] ppl_in [4];
   num_type            nsx7_ff, nsy7_ff;
   logic [63:0]        dmag7_ff;
   logic               degen7_ff, dneg7_ff;
   // stage 8
   num_type            t_ff [4];
   num_type            nsx8_ff, nsy8_ff;
   logic [63:0]        dmag8_ff;
   logic               degen8_ff, dneg8_ff;
   // stage 9
   num_type            nz9_ff, nsx9_ff, nsy9_ff;
   logic [63:0]        dmag9_ff;
   logic               degen9_ff, dneg9_ff;
   // divider side
   q16_type            z_div, sx_div, sy_div;
   logic [DIV_LAT-1:0] degen_dly_ff;
   // output
   logic [95:0]        rsp_data_ff;
   logic               rsp_degen_ff;

   assign entry_index = req_tdata[7:0];
   assign entry_value = req_tdata[39:8];
   assign query_x     = req_tdata[71:40];
   assign query_y     = req_tdata[103:72];

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 5'd2;
         col_count_ff <= 5'd2;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_ff <= csr_wdata;
            CSR_COL_COUNT: col_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // counts outside the legal range act as the nearest bound
   always_comb begin
      row_eff = (row_count_ff < 5'd2) ? 5'd2
              : (row_count_ff > ROW_CAP) ? ROW_CAP : row_count_ff;
      col_eff = (col_count_ff < 5'd2) ? 5'd2
              : (col_count_ff > COL_CAP) ? COL_CAP : col_count_ff;
   end

   // ---------------------------------------------------------------- handshake
   // one global enable; the pipe holds whole while the rsp beat waits
   assign adv        = !vld_ff[PIPE_LEN-1] || rsp_tready;
   assign is_query   = (req_tuser == KIND_QUERY);
   // loads write the stores at acceptance; stages 1..3 still read them
   assign front_busy = |vld_ff[2:0];
   assign req_tready = adv && (is_query || !front_busy);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LEN-2:0], accept && is_query};
      end
   end

   // ---------------------------------------------------------------- stores
   always_comb begin
      row_wr.en   = accept && (req_tuser == KIND_ROW_BP)
                  && ({1'b0, entry_index} < 9'(MAX_ROWS));
      row_wr.idx  = entry_index;
      row_wr.data = entry_value;
      col_wr.en   = accept && (req_tuser == KIND_COL_BP)
                  && ({1'b0, entry_index} < 9'(MAX_COLS));
      col_wr.idx  = entry_index;
      col_wr.data = entry_value;
      grid_we     = accept && (req_tuser == KIND_GRID)
                  && ({1'b0, entry_index} < 9'(GD));
   end

   // stages 1..4: clamp, search, breakpoint fetch
   bgi_axis #(.N(MAX_ROWS)) u_row (
      .clock    (clock),
      .adv      (adv),
      .wr       (row_wr),
      .count    (row_eff),
      .coord    (query_x),
      .cell_idx (row_cell),
      .lo       (row_lo),
      .hi       (row_hi),
      .pos      (row_pos)
   );

   bgi_axis #(.N(MAX_COLS)) u_col (
      .clock    (clock),
      .adv      (adv),
      .wr       (col_wr),
      .count    (col_eff),
      .coord    (query_y),
      .cell_idx (col_cell),
      .lo       (col_lo),
      .hi       (col_hi),
      .pos      (col_pos)
   );

   // corner addresses from the stage-3 cell
   always_comb begin
      base_w    = AW'(row_cell) + AW'(row_eff) * AW'(col_cell);
      base_up_w = base_w + AW'(1);
      base_rt_w = base_w + AW'(row_eff);
      base_dg_w = base_rt_w + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid0_mem[entry_index[GAW-1:0]] <= entry_value;
         grid1_mem[entry_index[GAW-1:0]] <= entry_value;
         grid2_mem[entry_index[GAW-1:0]] <= entry_value;
         grid3_mem[entry_index[GAW-1:0]] <= entry_value;
      end
      if (adv) begin
         a_ff[0] <= grid0_mem[base_w[GAW-1:0]];
         a_ff[1] <= grid1_mem[base_up_w[GAW-1:0]];
         a_ff[2] <= grid2_mem[base_rt_w[GAW-1:0]];
         a_ff[3] <= grid3_mem[base_dg_w[GAW-1:0]];
      end
   end

   // ---------------------------------------------------------------- math
   // stage 6 magnitudes of the cell widths
   always_comb begin
      dxm = dx_ff[32] ? 32'(-dx_ff) : 32'(dx_ff);
      dym = dy_ff[32] ? 32'(-dy_ff) : 32'(dy_ff);
   end

   // stage 7 partial products: 65-bit product split into signed high half
   // and unsigned low half
   always_comb begin
      logic signed [32:0] hi_part;
      logic signed [32:0] lo_part;
      for (int k = 0; k < 4; k++) begin
         hi_part   = p_ff[k][64:32];
         lo_part   = {1'b0, p_ff[k][31:0]};
         pph_in[k] = hi_part * ((k < 2) ? vy1_s6_ff : vy0_s6_ff);
         ppl_in[k] = lo_part * ((k < 2) ? vy1_s6_ff : vy0_s6_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 5: differences
         dx_ff  <= 33'(row_hi) - 33'(row_lo);
         dy_ff  <= 33'(col_hi) - 33'(col_lo);
         ux1_ff <= 33'(row_hi) - 33'(row_pos);
         ux0_ff <= 33'(row_pos) - 33'(row_lo);
         vy1_ff <= 33'(col_hi) - 33'(col_pos);
         vy0_ff <= 33'(col_pos) - 33'(col_lo);
         da_ff  <= 33'(a_ff[1]) - 33'(a_ff[0]);
         db_ff  <= 33'(a_ff[3]) - 33'(a_ff[2]);
         dc_ff  <= 33'(a_ff[2]) - 33'(a_ff[0]);
         dd_ff  <= 33'(a_ff[3]) - 33'(a_ff[1]);
         for (int k = 0; k < 4; k++) begin
            a5_ff[k] <= a_ff[k];
         end
         // stage 6: first products
         for (int k = 0; k < 4; k++) begin
            p_ff[k] <= a5_ff[k] * (((k % 2) == 0) ? ux1_ff : ux0_ff);
         end
         qa_ff     <= da_ff * vy1_ff;
         qb_ff     <= db_ff * vy0_ff;
         qc_ff     <= dc_ff * ux1_ff;
         qd_ff     <= dd_ff * ux0_ff;
         vy1_s6_ff <= vy1_ff;
         vy0_s6_ff <= vy0_ff;
         dmag6_ff  <= {32'b0, dxm} * {32'b0, dym};
         degen6_ff <= (dx_ff == '0) || (dy_ff == '0);
         dneg6_ff  <= dx_ff[32] ^ dy_ff[32];
         // stage 7: partial products, slope numerators
         for (int k = 0; k < 4; k++) begin
            pph_ff[k] <= pph_in[k];
            ppl_ff[k] <= ppl_in[k];
         end
         nsx7_ff   <= (NUM_W'(qa_ff) + NUM_W'(qb_ff)) <<< 16;
         nsy7_ff   <= (NUM_W'(qc_ff) + NUM_W'(qd_ff)) <<< 16;
         dmag7_ff  <= dmag6_ff;
         degen7_ff <= degen6_ff;
         dneg7_ff  <= dneg6_ff;
         // stage 8: corner terms
         for (int k = 0; k < 4; k++) begin
            t_ff[k] <= (NUM_W'(pph_ff[k]) <<< 32) + NUM_W'(ppl_ff[k]);
         end
         nsx8_ff   <= nsx7_ff;
         nsy8_ff   <= nsy7_ff;
         dmag8_ff  <= dmag7_ff;
         degen8_ff <= degen7_ff;
         dneg8_ff  <= dneg7_ff;
         // stage 9: value numerator
         nz9_ff    <= t_ff[0] + t_ff[1] + t_ff[2] + t_ff[3];
         nsx9_ff   <= nsx8_ff;
         nsy9_ff   <= nsy8_ff;
         dmag9_ff  <= dmag8_ff;
         degen9_ff <= degen8_ff;
         dneg9_ff  <= dneg8_ff;
         // divider-aligned flag and output register
         degen_dly_ff <= {degen_dly_ff[DIV_LAT-2:0], degen9_ff};
         rsp_degen_ff <= degen_dly_ff[DIV_LAT-1];
         rsp_data_ff  <= degen_dly_ff[DIV_LAT-1] ? 96'd0 : {sy_div, sx_div, z_div};
      end
   end

   // ---------------------------------------------------------------- divide
   bgi_div u_div_z (
      .clock   (clock),
      .adv     (adv),
      .num     (nz9_ff),
      .den_neg (dneg9_ff),
      .den_mag (dmag9_ff),
      .quot    (z_div)
   );

   bgi_div u_div_sx (
      .clock   (clock),
      .adv     (adv),
      .num     (nsx9_ff),
      .den_neg (dneg9_ff),
      .den_mag (dmag9_ff),
      .quot    (sx_div)
   );

   bgi_div u_div_sy (
      .clock   (clock),
      .adv     (adv),
      .num     (nsy9_ff),
      .den_neg (dneg9_ff),
      .den_mag (dmag9_ff),
      .quot    (sy_div)
   );

   assign rsp_tvalid = vld_ff[PIPE_LEN-1];
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_degen_ff;

   // ---------------------------------------------------------------- checks
   `BGI_ASSERT_IMP(a_degen_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "degenerate beat carries nonzero data")
   `BGI_ASSERT_NXT(a_query_enters, clock, reset, req_tvalid && req_tready && req_tuser == KIND_QUERY, vld_ff[0], "accepted query missing from stage 1")
   `BGI_ASSERT_NXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, $stable(vld_ff), "pipeline moved during stall")

endmodule

`default_nettype wire

[hw/rtl/bgi_axis.sv]
// One axis of the interpolator: breakpoint store, clamp and cell search.
// Depends on bgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgi_axis #(
   parameter int N = 16,
   localparam int IW = $clog2(N)
) (
   input  logic                 clock,
   input  logic                 adv,
   input  bgi_pkg::bp_wr_type   wr,
   input  logic [4:0]           count,
   input  bgi_pkg::q16_type     coord,
   output logic [IW-1:0]        cell_idx,
   output bgi_pkg::q16_type     lo,
   output bgi_pkg::q16_type     hi,
   output bgi_pkg::q16_type     pos
);
   import bgi_pkg::*;

   q16_type          bp_ff [N];
   q16_type          s1_ff, s2_ff, s3_pos_ff, s4_pos_ff, s4_lo_ff, s4_hi_ff;
   logic [IW-1:0]    s3_cell_ff;
   logic [IW-1:0]    last_idx;
   logic [IW-1:0]    cell_in;
   q16_type          clamp_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         bp_ff[wr.idx[IW-1:0]] <= wr.data;
      end
   end

   // clamp to the table border
   always_comb begin
      last_idx = IW'(count - 5'd1);
      if (s1_ff < bp_ff[0]) begin
         clamp_in = bp_ff[0];
      end else if (s1_ff > bp_ff[last_idx]) begin
         clamp_in = bp_ff[last_idx];
      end else begin
         clamp_in = s1_ff;
      end
   end

   // lowest bracketing cell; last cell when none brackets
   always_comb begin
      cell_in = IW'(count - 5'd2);
      for (int k = N - 2; k >= 0; k--) begin
         if ((k + 1 < int'(count)) && (bp_ff[k+1] >= s2_ff) && (s2_ff >= bp_ff[k])) begin
            cell_in = IW'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff      <= coord;
         s2_ff      <= clamp_in;
         s3_pos_ff  <= s2_ff;
         s3_cell_ff <= cell_in;
         s4_pos_ff  <= s3_pos_ff;
         s4_lo_ff   <= bp_ff[s3_cell_ff];
         s4_hi_ff   <= bp_ff[s3_cell_ff + IW'(1)];
      end
   end

   assign cell_idx = s3_cell_ff;
   assign lo       = s4_lo_ff;
   assign hi       = s4_hi_ff;
   assign pos      = s4_pos_ff;

endmodule

`default_nettype wire

[hw/rtl/bgi_div.sv]
// Pipelined restoring divider: signed numerator over signed 64-bit divisor,
// rounded half away from zero, saturated to 32 bits. Depends on bgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgi_div (
   input  logic               clock,
   input  logic               adv,
   input  bgi_pkg::num_type   num,
   input  logic               den_neg,
   input  logic [63:0]        den_mag,
   output bgi_pkg::q16_type   quot
);
   import bgi_pkg::*;

   logic [63:0]       rem_ff [DIV_NS+1];
   logic [63:0]       rem_in [DIV_NS+1];
   logic [QBITS-1:0]  low_ff [DIV_NS+1];
   logic [QBITS-1:0]  low_in [DIV_NS+1];
   logic [QBITS-1:0]  q_ff   [DIV_NS+1];
   logic [QBITS-1:0]  q_in   [DIV_NS+1];
   logic [63:0]       den_ff [DIV_NS+1];
   logic              neg_ff [DIV_NS+1];
   logic              sat_ff [DIV_NS+1];
   logic              sat_in;
   q16_type           quot_ff;
   q16_type           quot_in;

   always_comb begin
      logic [NUM_W-1:0]  mag;
      logic [64:0]       trial;
      logic [63:0]       r;
      logic [QBITS-1:0]  q;
      logic [QBITS-1:0]  lw;
      mag = num[NUM_W-1] ? (~$unsigned(num) + NUM_W'(1)) : $unsigned(num);
      // quotient of 2^32 or more saturates
      sat_in    = mag[NUM_W-1:QBITS] >= (NUM_W-QBITS)'(den_mag);
      rem_in[0] = mag[QBITS+63:QBITS];
      low_in[0] = mag[QBITS-1:0];
      q_in[0]   = '0;
      for (int g = 1; g <= DIV_NS; g++) begin
         r  = rem_ff[g-1];
         q  = q_ff[g-1];
         lw = low_ff[g-1];
         for (int s = 0; s < DIV_SPS; s++) begin
            trial = {r, lw[QBITS-1]};
            lw    = {lw[QBITS-2:0], 1'b0};
            if (trial >= {1'b0, den_ff[g-1]}) begin
               r = 64'(trial - {1'b0, den_ff[g-1]});
               q = {q[QBITS-2:0], 1'b1};
            end else begin
               r = trial[63:0];
               q = {q[QBITS-2:0], 1'b0};
            end
         end
         rem_in[g] = r;
         q_in[g]   = q;
         low_in[g] = lw;
      end
   end

   // round, saturate, apply sign
   always_comb begin
      logic [64:0]      twice_rem;
      logic [QBITS:0]   qr;
      logic [QBITS:0]   lim;
      twice_rem = {rem_ff[DIV_NS], 1'b0};
      qr = {1'b0, q_ff[DIV_NS]}
         + ((twice_rem >= {1'b0, den_ff[DIV_NS]}) ? (QBITS+1)'(1) : (QBITS+1)'(0));
      lim = neg_ff[DIV_NS] ? ((QBITS+1)'(1) << (QBITS-1))
                           : (((QBITS+1)'(1) << (QBITS-1)) - (QBITS+1)'(1));
      if (sat_ff[DIV_NS] || (qr > lim)) begin
         qr = lim;
      end
      quot_in = neg_ff[DIV_NS] ? QBITS'(-qr) : QBITS'(qr);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= rem_in[0];
         low_ff[0] <= low_in[0];
         q_ff[0]   <= q_in[0];
         den_ff[0] <= den_mag;
         neg_ff[0] <= num[NUM_W-1] ^ den_neg;
         sat_ff[0] <= sat_in;
         for (int g = 1; g <= DIV_NS; g++) begin
            rem_ff[g] <= rem_in[g];
            low_ff[g] <= low_in[g];
            q_ff[g]   <= q_in[g];
            den_ff[g] <= den_ff[g-1];
            neg_ff[g] <= neg_ff[g-1];
            sat_ff[g] <= sat_ff[g-1];
         end
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire
